[design/pts_pkg.sv]
`default_nettype none
package pts_pkg;

    // Default table depth
    localparam int MAX_TASKS_DEF = 8;

    // Command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  task_handle;
        logic [31:0] interval_ms;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       fired;
        logic [7:0] fired_handle;
        logic       last;
    } rsp_t;

    // One row of the task table
    typedef struct packed {
        logic [7:0]  handle;
        logic [31:0] period;
        logic [31:0] last_run;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TK_RD,
        S_TK_EV,
        S_TK_FIN,
        S_RM_RD,
        S_RM_EV,
        S_SH_RD,
        S_SH_WR
    } state_t;

endpackage
`default_nettype wire

[design/pts_ram.sv]
`default_nettype none
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[design/periodic_task_scheduler.sv]
`default_nettype none
// Add, invalid and immediate commands: result strobed in the cycle after start; busy stays low.
// Tick (table not empty): each entry is read, then checked (one read port, one deadline
//   compare); a due task strobes when the next due task is found or the walk ends.
// Remove (table not empty, handle nonzero): entries are searched, then each entry above the
//   match is shifted down one place. A new item is taken once busy falls.
// Reset (rst_n, asynchronous) empties the table; there is no clearing pass. Results
//   cannot be held off by the receiver.
module periodic_task_scheduler #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pts_pkg::req_t req,
    output logic               rsp_valid,
    output pts_pkg::rsp_t      rsp
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

    pts_pkg::state_t state_reg, state_next;
    pts_pkg::req_t   req_reg, req_next;
    pts_pkg::rsp_t   rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic            pend_vld_reg, pend_vld_next;
    logic [7:0]      pend_handle_reg, pend_handle_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    pts_pkg::entry_t  wr_data;
    pts_pkg::entry_t  rd_data;
    logic [$bits(pts_pkg::entry_t)-1:0] rd_raw;

    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W-1:0] pos_inc2;
    logic [31:0]      elapsed;
    logic             due;

    function automatic pts_pkg::rsp_t make_rsp(input logic [1:0] status,
                                               input logic       fired,
                                               input logic [7:0] handle,
                                               input logic       last);
        pts_pkg::rsp_t r;
        r.status       = status;
        r.fired        = fired;
        r.fired_handle = handle;
        r.last         = last;
        return r;
    endfunction

    pts_ram #(
        .WIDTH ($bits(pts_pkg::entry_t)),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_data  = pts_pkg::entry_t'(rd_raw);
    assign pos_inc  = pos_reg + ONE;
    assign pos_inc2 = pos_reg + TWO;

    // Shared deadline unit: wrap-safe elapsed time against the period
    assign elapsed = req_reg.now_ms - rd_data.last_run;
    assign due     = (elapsed >= rd_data.period);

    assign busy      = (state_reg != pts_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pts_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            pos_reg       <= '0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        rsp_reg         <= rsp_next;
        pend_handle_reg <= pend_handle_next;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = 1'b0;
        count_next       = count_reg;
        pos_next         = pos_reg;
        pend_vld_next    = pend_vld_reg;
        pend_handle_next = pend_handle_reg;
        wr_en            = 1'b0;
        wr_addr          = pos_reg[IDX_W-1:0];
        wr_data          = rd_data;
        rd_addr          = pos_reg[IDX_W-1:0];

        unique case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next      = req;
                    pos_next      = '0;
                    pend_vld_next = 1'b0;
                    unique case (req.cmd)
                        pts_pkg::CMD_ADD:
                        begin
                            rsp_valid_next = 1'b1;
                            priority if (req.task_handle == 8'd0)
                            begin
                                rsp_next = make_rsp(pts_pkg::ST_INVALID, 1'b0, 8'd0, 1'b1);
                            end
                            else if (count_reg >= MAX_CNT)
                            begin
                                rsp_next = make_rsp(pts_pkg::ST_FULL, 1'b0, 8'd0, 1'b1);
                            end
                            else
                            begin
                                // Append at the end of the table
                                wr_en            = 1'b1;
                                wr_addr          = count_reg[IDX_W-1:0];
                                wr_data.handle   = req.task_handle;
                                wr_data.period   = req.interval_ms;
                                wr_data.last_run = req.now_ms;
                                count_next       = count_reg + ONE;
                                rsp_next = make_rsp(pts_pkg::ST_OK, 1'b0, 8'd0, 1'b1);
                            end
                        end
                        pts_pkg::CMD_REMOVE:
                        begin
                            priority if (req.task_handle == 8'd0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(pts_pkg::ST_INVALID, 1'b0, 8'd0, 1'b1);
                            end
                            else if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(pts_pkg::ST_NOT_FOUND, 1'b0, 8'd0, 1'b1);
                            end
                            else
                            begin
                                state_next = pts_pkg::S_RM_RD;
                            end
                        end
                        pts_pkg::CMD_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(pts_pkg::ST_OK, 1'b0, 8'd0, 1'b1);
                            end
                            else
                            begin
                                state_next = pts_pkg::S_TK_RD;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next = make_rsp(pts_pkg::ST_INVALID, 1'b0, 8'd0, 1'b1);
                        end
                    endcase
                end
            end

            pts_pkg::S_TK_RD:
            begin
                state_next = pts_pkg::S_TK_EV;
            end

            pts_pkg::S_TK_EV:
            begin
                // Restart a due task and release the previous one held back
                if (due)
                begin
                    wr_en            = 1'b1;
                    wr_data.last_run = req_reg.now_ms;
                    if (pend_vld_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next = make_rsp(pts_pkg::ST_OK, 1'b1, pend_handle_reg, 1'b0);
                    end
                    pend_vld_next    = 1'b1;
                    pend_handle_next = rd_data.handle;
                end
                pos_next = pos_inc;
                if (pos_inc == count_reg)
                begin
                    state_next = pts_pkg::S_TK_FIN;
                end
                else
                begin
                    state_next = pts_pkg::S_TK_RD;
                end
            end

            pts_pkg::S_TK_FIN:
            begin
                // Close the tick with the held task, or a quiet result
                rsp_valid_next = 1'b1;
                if (pend_vld_reg)
                begin
                    rsp_next = make_rsp(pts_pkg::ST_OK, 1'b1, pend_handle_reg, 1'b1);
                end
                else
                begin
                    rsp_next = make_rsp(pts_pkg::ST_OK, 1'b0, 8'd0, 1'b1);
                end
                pend_vld_next = 1'b0;
                state_next    = pts_pkg::S_IDLE;
            end

            pts_pkg::S_RM_RD:
            begin
                state_next = pts_pkg::S_RM_EV;
            end

            pts_pkg::S_RM_EV:
            begin
                priority if (rd_data.handle == req_reg.task_handle)
                begin
                    if (pos_inc < count_reg)
                    begin
                        state_next = pts_pkg::S_SH_RD;
                    end
                    else
                    begin
                        count_next     = count_reg - ONE;
                        rsp_valid_next = 1'b1;
                        rsp_next = make_rsp(pts_pkg::ST_OK, 1'b0, 8'd0, 1'b1);
                        state_next     = pts_pkg::S_IDLE;
                    end
                end
                else if (pos_inc == count_reg)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next = make_rsp(pts_pkg::ST_NOT_FOUND, 1'b0, 8'd0, 1'b1);
                    state_next     = pts_pkg::S_IDLE;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = pts_pkg::S_RM_RD;
                end
            end

            pts_pkg::S_SH_RD:
            begin
                // Fetch the entry above the gap
                rd_addr    = pos_inc[IDX_W-1:0];
                state_next = pts_pkg::S_SH_WR;
            end

            pts_pkg::S_SH_WR:
            begin
                // Move it down one place
                wr_en = 1'b1;
                if (pos_inc2 == count_reg)
                begin
                    count_next     = count_reg - ONE;
                    rsp_valid_next = 1'b1;
                    rsp_next = make_rsp(pts_pkg::ST_OK, 1'b0, 8'd0, 1'b1);
                    state_next     = pts_pkg::S_IDLE;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = pts_pkg::S_SH_RD;
                end
            end

            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("task count beyond table depth");

    a_fired_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fired |-> rsp.fired_handle != 8'd0)
        else $error("fired result with zero handle");

    a_quiet_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.fired |-> rsp.last)
        else $error("non-fired result not marked last");

    a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.cmd != pts_pkg::CMD_TICK && req.cmd != pts_pkg::CMD_REMOVE
        |=> rsp_valid && rsp.last && !busy)
        else $error("add or invalid command did not answer at once");
`endif

endmodule
`default_nettype wire
